/* hdl/lfd_pkg.sv */
// ============================================================================
// lfd_pkg: shared constants and types of the fractional delay line
// Store depth, field widths, request codes and sequencer states.
// ============================================================================
`default_nettype none

package lfd_pkg;

    // store geometry
    localparam int BUFFER_DEPTH = 4096;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int POS_W        = IDX_W + 16;

    // field widths
    localparam int OP_W     = 3;
    localparam int SAMPLE_W = 24;
    localparam int TAPD_W   = 12;
    localparam int FRAC_W   = 16;
    localparam int DELAY_W  = 28;
    localparam int COEF_W   = 18;
    localparam int IN_W     = 56;

    // fixed point
    localparam int Q16_ONE    = 65536;
    localparam int SAMPLE_MAX = 8388607;

    // request codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK        = 3'd0,
        OP_TICK_IN     = 3'd1,
        OP_TICK_OUT    = 3'd2,
        OP_TAP_OUT     = 3'd3,
        OP_TAP_IN      = 3'd4,
        OP_ADD_TO      = 3'd5,
        OP_TAP_INTERP  = 3'd6
    } t_op;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_COEF,
        ST_INTERP,
        ST_RND,
        ST_TAPRD,
        ST_ADD
    } t_state;

endpackage

`default_nettype wire

/* hdl/lagrange_frac_delay_line.sv */
// ============================================================================
// lagrange_frac_delay_line: cubic Lagrange fractional delay line
// Circular sample store with tap access and 4-point interpolated reads,
// built around one shared signed multiplier under a small sequencer.
// ============================================================================
//
//  channel   | dir | fields (lsb first)
//  ----------+-----+------------------------------------------------------
//  s_axis    | in  | tdata: op[2:0] sample[26:3] tap_delay[38:27] tap_frac[54:39]
//  m_axis    | out | tdata: out_sample[23:0]
//  cfg       | in  | wdata: delay_q16[27:0]
//
//  after reset the store is cleared one entry a cycle with tready low; delay
//  writes are taken meanwhile.
//  tick / tick_out: 4 single-port store reads feed the multiplier.
//  tap_out_interpolated: 8 coefficient steps on the multiplier come first.
//  delay write: coefficient work runs before tready rises again.
//  tap_out / add_to read the store first; tick_in / tap_in end on accept; results
//  wait in an output register, a full register holds the sequencer in its result state.
`default_nettype none

module lagrange_frac_delay_line (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // op, sample, tap_delay, tap_frac from bit 0 up
    input  wire logic [lfd_pkg::IN_W-1:0]      i_s_axis_tdata,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // out_sample
    output logic [lfd_pkg::SAMPLE_W-1:0]       o_m_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    input  wire logic                          i_cfg_we,
    input  wire logic [lfd_pkg::DELAY_W-1:0]   i_cfg_wdata
);

    import lfd_pkg::*;

    // coefficient rounding: numerator / (6 or 2 * 2^32), half away from zero
    function automatic logic signed [COEF_W-1:0] coef_round(
        input logic signed [53:0] p,
        input logic               neg,
        input logic               div6
    );
        logic [53:0] mag;
        logic [20:0] v;
        logic [41:0] prod3;
        logic [COEF_W-1:0] q;
        logic sgn;
        mag = p[53] ? 54'(-p) : 54'(p);
        sgn = p[53] ^ neg;
        if (div6) begin
            v     = 21'((mag + (54'd3 << 32)) >> 33);
            prod3 = 42'(v) * 42'd699051;
            q     = COEF_W'(prod3 >> 21);
        end else begin
            v     = '0;
            prod3 = '0;
            q     = COEF_W'((mag + (54'd1 << 32)) >> 33);
        end
        return sgn ? -$signed(q) : $signed(q);
    endfunction

    // state
    t_state                    r_state, n_state;
    logic [IDX_W-1:0]          r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0]          r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]          r_clr, n_clr;
    logic [IDX_W-1:0]          r_base, n_base;
    logic [IDX_W-1:0]          r_tap, n_tap;
    logic [2:0]                r_cnt, n_cnt;
    logic [16:0]               r_cfg_a, n_cfg_a;
    logic [16:0]               r_calc_a, n_calc_a;
    logic                      r_cfg_pend, n_cfg_pend;
    logic                      r_item, n_item;
    logic signed [SAMPLE_W-1:0] r_smp, n_smp;
    logic signed [SAMPLE_W-1:0] r_out, n_out;
    logic                      r_out_valid, n_out_valid;
    logic signed [COEF_W-1:0]  r_coef [4];
    logic signed [COEF_W-1:0]  n_coef [4];
    logic signed [COEF_W-1:0]  r_icoef [4];
    logic signed [COEF_W-1:0]  n_icoef [4];
    logic signed [53:0]        r_prod;
    logic signed [34:0]        r_t, n_t;
    logic signed [44:0]        r_acc, n_acc;

    // store
    logic signed [SAMPLE_W-1:0] mem [BUFFER_DEPTH];
    logic signed [SAMPLE_W-1:0] r_mem_q;
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_addr;
    logic signed [SAMPLE_W-1:0] mem_wdata;

    // shared multiplier operands
    logic signed [34:0] mul_a;
    logic signed [18:0] mul_b;

    // input decode
    t_op                        in_op;
    logic signed [SAMPLE_W-1:0] in_smp;
    logic [TAPD_W-1:0]          in_tapd;
    logic [FRAC_W-1:0]          in_frac;
    logic                       in_acc;
    logic                       out_free;
    logic [IDX_W-1:0]           tap_addr;

    // coefficient helpers
    logic signed [18:0]  s_a, am1, am2, ap1;
    logic signed [34:0]  ea, pb;
    logic                fin_neg, fin_div6;
    logic signed [COEF_W-1:0] fin_val;
    logic [1:0]          coef_idx;
    logic signed [COEF_W-1:0] coef_sel;

    // rounding and saturation helpers
    logic [44:0]        amag;
    logic [28:0]        qr;
    logic signed [SAMPLE_W-1:0] rnd_res;
    logic signed [SAMPLE_W:0]   add_sum;
    logic signed [SAMPLE_W-1:0] add_res;
    logic [POS_W-1:0]   cfg_m, cfg_pos;

    assign in_op    = t_op'(i_s_axis_tdata[2:0]);
    assign in_smp   = $signed(i_s_axis_tdata[26:3]);
    assign in_tapd  = i_s_axis_tdata[38:27];
    assign in_frac  = i_s_axis_tdata[54:39];
    assign o_s_axis_tready = (r_state == ST_IDLE) && !r_cfg_pend;
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign tap_addr = r_wr_idx - IDX_W'(in_tapd) - 1'b1;

    assign o_m_axis_tdata  = r_out;
    assign o_m_axis_tvalid = r_out_valid;

    // lagrange factors of the current fraction
    assign s_a = $signed({2'b00, r_calc_a});
    assign am1 = s_a - 19'sd65536;
    assign am2 = s_a - 19'sd131072;
    assign ap1 = s_a + 19'sd65536;
    assign ea  = 35'(s_a);
    assign pb  = $signed(r_prod[34:0]);
    assign fin_val = coef_round(r_prod, fin_neg, fin_div6);

    // interpolation tap coefficient
    assign coef_idx = 2'(r_cnt - 3'd1);
    assign coef_sel = r_item ? r_icoef[coef_idx] : r_coef[coef_idx];

    // final rounding of the accumulated sum
    always_comb begin
        amag = r_acc[44] ? 45'(-r_acc) : 45'(r_acc);
        qr   = 29'((amag + 45'd32768) >> 16);
        if (!r_acc[44]) begin
            rnd_res = (qr > 29'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX) : $signed(qr[23:0]);
        end else begin
            rnd_res = (qr > 29'(SAMPLE_MAX + 1)) ? $signed(24'h800000)
                                                 : $signed(SAMPLE_W'(-qr));
        end
    end

    // saturated add for add_to
    always_comb begin
        add_sum = 25'(r_mem_q) + 25'(r_smp);
        if (add_sum > 25'sd8388607) begin
            add_res = SAMPLE_W'(SAMPLE_MAX);
        end else if (add_sum < -25'sd8388608) begin
            add_res = $signed(24'h800000);
        end else begin
            add_res = add_sum[SAMPLE_W-1:0];
        end
    end

    // read position from the delay write
    assign cfg_m   = POS_W'(i_cfg_wdata) + POS_W'(Q16_ONE);
    assign cfg_pos = {r_wr_idx, 16'b0} - cfg_m;

    // sequencer next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_clr       = r_clr;
        n_base      = r_base;
        n_tap       = r_tap;
        n_cnt       = r_cnt;
        n_cfg_a     = r_cfg_a;
        n_calc_a    = r_calc_a;
        n_cfg_pend  = r_cfg_pend;
        n_item      = r_item;
        n_smp       = r_smp;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_coef      = r_coef;
        n_icoef     = r_icoef;
        n_t         = r_t;
        n_acc       = r_acc;
        mem_we      = 1'b0;
        mem_addr    = r_tap;
        mem_wdata   = r_smp;
        mul_a       = ea;
        mul_b       = am1;
        fin_neg     = 1'b0;
        fin_div6    = 1'b1;

        unique case (r_state)
            ST_CLR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == IDX_W'(BUFFER_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (r_cfg_pend) begin
                    n_calc_a   = r_cfg_a;
                    n_item     = 1'b0;
                    n_cfg_pend = 1'b0;
                    n_cnt      = '0;
                    n_state    = ST_COEF;
                end else if (in_acc) begin
                    case (in_op) inside
                        OP_TICK, OP_TICK_IN: begin
                            mem_we    = 1'b1;
                            mem_addr  = r_wr_idx;
                            mem_wdata = in_smp;
                            n_wr_idx  = r_wr_idx + 1'b1;
                            if (in_op == OP_TICK) begin
                                n_base  = r_rd_idx - 1'b1;
                                n_rd_idx = r_rd_idx + 1'b1;
                                n_item  = 1'b0;
                                n_cnt   = '0;
                                n_state = ST_INTERP;
                            end
                        end
                        OP_TICK_OUT: begin
                            n_base   = r_rd_idx - 1'b1;
                            n_rd_idx = r_rd_idx + 1'b1;
                            n_item   = 1'b0;
                            n_cnt    = '0;
                            n_state  = ST_INTERP;
                        end
                        OP_TAP_OUT: begin
                            mem_addr = tap_addr;
                            n_tap    = tap_addr;
                            n_state  = ST_TAPRD;
                        end
                        OP_TAP_IN: begin
                            mem_we    = 1'b1;
                            mem_addr  = tap_addr;
                            mem_wdata = in_smp;
                        end
                        OP_ADD_TO: begin
                            mem_addr = tap_addr;
                            n_tap    = tap_addr;
                            n_smp    = in_smp;
                            n_state  = ST_ADD;
                        end
                        OP_TAP_INTERP: begin
                            n_calc_a = 17'(Q16_ONE) - 17'(in_frac);
                            n_base   = r_wr_idx - IDX_W'(in_tapd) - IDX_W'(3);
                            n_item   = 1'b1;
                            n_cnt    = '0;
                            n_state  = ST_COEF;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            // eight steps, coefficients finished at steps 2, 3, 5 and 7
            ST_COEF: begin
                n_cnt = r_cnt + 1'b1;
                case (r_cnt)
                    3'd0: begin
                        mul_a = ea;
                        mul_b = am1;
                    end
                    3'd1: begin
                        n_t   = pb;
                        mul_a = pb;
                        mul_b = am2;
                    end
                    3'd2: begin
                        fin_neg = 1'b1;
                        if (r_item) n_icoef[0] = fin_val;
                        else        n_coef[0]  = fin_val;
                        mul_a = r_t;
                        mul_b = ap1;
                    end
                    3'd3: begin
                        if (r_item) n_icoef[3] = fin_val;
                        else        n_coef[3]  = fin_val;
                        mul_a = ea;
                        mul_b = am2;
                    end
                    3'd4: begin
                        mul_a = pb;
                        mul_b = ap1;
                    end
                    3'd5: begin
                        fin_neg  = 1'b1;
                        fin_div6 = 1'b0;
                        if (r_item) n_icoef[2] = fin_val;
                        else        n_coef[2]  = fin_val;
                        mul_a = 35'(am1);
                        mul_b = am2;
                    end
                    3'd6: begin
                        mul_a = pb;
                        mul_b = ap1;
                    end
                    default: begin
                        fin_div6 = 1'b0;
                        if (r_item) n_icoef[1] = fin_val;
                        else        n_coef[1]  = fin_val;
                        n_cnt   = '0;
                        n_state = r_item ? ST_INTERP : ST_IDLE;
                    end
                endcase
            end

            // read, multiply and accumulate overlap across four taps
            ST_INTERP: begin
                n_cnt    = r_cnt + 1'b1;
                mem_addr = r_base + IDX_W'(r_cnt[1:0]);
                if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                    mul_a = 35'(r_mem_q);
                    mul_b = 19'(coef_sel);
                end
                if (r_cnt == 3'd0) begin
                    n_acc = '0;
                end else if (r_cnt >= 3'd2) begin
                    n_acc = r_acc + 45'(r_prod);
                end
                if (r_cnt == 3'd5) begin
                    n_state = ST_RND;
                end
            end

            ST_RND: begin
                if (out_free) begin
                    n_out       = rnd_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            ST_TAPRD: begin
                if (out_free) begin
                    n_out       = r_mem_q;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            ST_ADD: begin
                if (out_free) begin
                    mem_we      = 1'b1;
                    mem_wdata   = add_res;
                    n_out       = add_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // delay write places the read pointer and queues the coefficients
        if (i_cfg_we) begin
            n_rd_idx   = cfg_pos[POS_W-1:16];
            n_cfg_a    = {1'b0, cfg_pos[15:0]};
            n_cfg_pend = 1'b1;
        end
    end

    // sample store, single port with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_mem_q <= mem[mem_addr];
    end

    // shared multiplier and payload registers
    always_ff @(posedge i_clk) begin
        r_prod   <= mul_a * mul_b;
        r_t      <= n_t;
        r_acc    <= n_acc;
        r_base   <= n_base;
        r_tap    <= n_tap;
        r_smp    <= n_smp;
        r_out    <= n_out;
        r_calc_a <= n_calc_a;
        r_cnt    <= n_cnt;
        r_item   <= n_item;
        r_icoef  <= n_icoef;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_cfg_a     <= '0;
            r_cfg_pend  <= 1'b0;
            r_out_valid <= 1'b0;
            r_coef[0]   <= '0;
            r_coef[1]   <= COEF_W'(Q16_ONE);
            r_coef[2]   <= '0;
            r_coef[3]   <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_wr_idx    <= n_wr_idx;
            r_rd_idx    <= n_rd_idx;
            r_cfg_a     <= n_cfg_a;
            r_cfg_pend  <= n_cfg_pend;
            r_out_valid <= n_out_valid;
            r_coef      <= n_coef;
        end
    end

    // write pointer advances by one on a write-only tick
    a_tick_in_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_op == OP_TICK_IN) |=> (r_wr_idx == IDX_W'($past(r_wr_idx) + 1'b1)))
        else $error("write pointer did not advance on tick_in");

    // a delay write always leads to a coefficient update
    a_cfg_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> r_cfg_pend)
        else $error("delay write not queued");

    // an unknown request leaves the sequencer idle
    a_bad_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_axis_tdata[2:0] == 3'd7) |=> (r_state == ST_IDLE))
        else $error("unknown request started work");

endmodule

`default_nettype wire

/* verif/lagrange_frac_delay_line_tb.sv */
// ============================================================================
// lagrange_frac_delay_line_tb: self-checking bench for the fractional delay line
// Drives random and directed requests on the input stream, predicts every
// result from a behavioural model of the store and coefficients, and checks
// the output stream in order under varying idle patterns and back-pressure.
// ============================================================================
`timescale 1ns / 1ps

module lagrange_frac_delay_line_tb;
    import lfd_pkg::*;

    localparam int DEPTH     = BUFFER_DEPTH;
    localparam int CYC_LIMIT = 400000;

    // delay line model and result queue
    class delay_line_scoreboard;
        logic signed [SAMPLE_W-1:0] store [DEPTH];
        logic [IDX_W-1:0] wr_idx, rd_idx;
        longint h0, h1, h2, h3;
        logic signed [SAMPLE_W-1:0] pending [$];
        int errors;

        function new();
            foreach (store[i]) store[i] = '0;
            wr_idx = '0;
            rd_idx = '0;
            h0 = 0; h1 = Q16_ONE; h2 = 0; h3 = 0;
            errors = 0;
        endfunction

        function longint rnd_div(longint num, longint den);
            longint m;
            m = (num < 0) ? -num : num;
            m = (m + den / 2) / den;
            return (num < 0) ? -m : m;
        endfunction

        function longint sat(longint v);
            if (v > SAMPLE_MAX) return SAMPLE_MAX;
            if (v < -SAMPLE_MAX - 1) return -SAMPLE_MAX - 1;
            return v;
        endfunction

        function void coefs(longint a, output longint c0, c1, c2, c3);
            longint u, uu, ap1, am1, am2;
            u = Q16_ONE;
            uu = 64'd1 << 32;
            ap1 = a + u; am1 = a - u; am2 = a - 2 * u;
            c0 = rnd_div(-(a * am1 * am2), 6 * uu);
            c1 = rnd_div(ap1 * am1 * am2, 2 * uu);
            c2 = rnd_div(-(ap1 * a * am2), 2 * uu);
            c3 = rnd_div(ap1 * a * am1, 6 * uu);
        endfunction

        function longint interp(logic [IDX_W-1:0] base, longint c0, c1, c2, c3);
            longint acc;
            logic [IDX_W-1:0] at;
            at = base - 1'b1;
            acc = longint'(store[at]) * c0;
            at = base;
            acc += longint'(store[at]) * c1;
            at = base + 1'b1;
            acc += longint'(store[at]) * c2;
            at = base + 2'd2;
            acc += longint'(store[at]) * c3;
            return sat(rnd_div(acc, Q16_ONE));
        endfunction

        function void set_delay(logic [DELAY_W-1:0] d);
            longint span, m, pos;
            span = longint'(DEPTH) << 16;
            m = (longint'(d) + Q16_ONE) % span;
            pos = ((longint'(wr_idx) << 16) + span - m) % span;
            rd_idx = IDX_W'(pos >> 16);
            coefs(pos & 16'hFFFF, h0, h1, h2, h3);
        endfunction

        // note an accepted request
        function void note_request(logic [IN_W-1:0] d);
            logic [OP_W-1:0] op;
            logic signed [SAMPLE_W-1:0] smp;
            logic [TAPD_W-1:0] td;
            logic [FRAC_W-1:0] fr;
            logic [IDX_W-1:0] tap;
            longint c0, c1, c2, c3, r;
            op  = d[2:0];
            smp = d[26:3];
            td  = d[38:27];
            fr  = d[54:39];
            tap = wr_idx - td - 1'b1;
            case (op) inside
                OP_TICK, OP_TICK_IN, OP_TICK_OUT: begin
                    if (op != OP_TICK_OUT) begin
                        store[wr_idx] = smp;
                        wr_idx++;
                    end
                    if (op != OP_TICK_IN) begin
                        pending.push_back(SAMPLE_W'(interp(rd_idx, h0, h1, h2, h3)));
                        rd_idx++;
                    end
                end
                OP_TAP_OUT: pending.push_back(store[tap]);
                OP_TAP_IN: store[tap] = smp;
                OP_ADD_TO: begin
                    r = sat(longint'(store[tap]) + longint'(smp));
                    store[tap] = SAMPLE_W'(r);
                    pending.push_back(SAMPLE_W'(r));
                end
                OP_TAP_INTERP: begin
                    coefs(Q16_ONE - longint'(fr), c0, c1, c2, c3);
                    pending.push_back(SAMPLE_W'(interp(wr_idx - td - 2'd2, c0, c1, c2, c3)));
                end
                default: ;
            endcase
        endfunction

        // check one accepted result
        function void check_result(logic [SAMPLE_W-1:0] got);
            logic [SAMPLE_W-1:0] want;
            if (pending.size() == 0) begin
                $error("out_sample: nothing expected, actual %0d", $signed(got));
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $error("out_sample: expected %0d, actual %0d", $signed(want), $signed(got));
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic [IN_W-1:0]     s_tdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [SAMPLE_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic                cfg_we;
    logic [DELAY_W-1:0]  cfg_wdata;

    delay_line_scoreboard sb;
    int  send_idle_pct, recv_idle_pct;
    int  hold_off;
    bit  finished;
    longint cycles;

    lagrange_frac_delay_line dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // timeout watch
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls plus a long hold-off window
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid stays up after an accept until the next request or a pause
    task automatic send_request(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] smp,
                                logic [TAPD_W-1:0] td, logic [FRAC_W-1:0] fr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {1'b0, fr, td, smp, op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request({1'b0, fr, td, smp, op});
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_delay(logic [DELAY_W-1:0] d);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_delay(d);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // mostly ticks, with tap traffic and the unknown code mixed in
    task automatic random_phase(int n);
        int k;
        logic [OP_W-1:0] op;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(19)) inside
                0, 1, 2, 3, 4, 5, 6, 7: op = OP_TICK;
                8, 9:   op = OP_TICK_IN;
                10, 11: op = OP_TICK_OUT;
                12, 13: op = OP_TAP_OUT;
                14:     op = OP_TAP_IN;
                15, 16: op = OP_ADD_TO;
                17, 18: op = OP_TAP_INTERP;
                default: op = 3'd7;
            endcase
            send_request(op, rand_sample(),
                         TAPD_W'(($urandom_range(3) == 0) ? $urandom : $urandom_range(40)),
                         FRAC_W'($urandom));
        end
    endtask

    initial begin
        logic [DELAY_W-1:0] dly;
        sb = new();
        cycles = 0;
        hold_off = 0;
        send_idle_pct = 16;
        recv_idle_pct = 52;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every request kind, wraps and the ignored code
        send_request(OP_TICK, 24'h7FFFFF, 0, 0);
        send_request(OP_TICK, 24'h800000, 0, 0);
        send_request(OP_TICK_IN, 24'h123456, 0, 0);
        send_request(OP_TICK_OUT, 0, 0, 0);
        send_request(OP_TAP_OUT, 0, 0, 0);
        send_request(OP_TAP_OUT, 0, 12'hFFF, 0);
        send_request(OP_TAP_IN, 24'h7FFFFF, 1, 0);
        send_request(OP_ADD_TO, 24'h7FFFFF, 1, 0);
        send_request(OP_ADD_TO, 24'h800000, 2, 0);
        send_request(OP_ADD_TO, 24'h800000, 2, 0);
        send_request(OP_TAP_INTERP, 0, 0, 0);
        send_request(OP_TAP_INTERP, 0, 1, 16'hFFFF);
        send_request(OP_TAP_INTERP, 0, 12'hFFF, 16'h8000);
        send_request(3'd7, 24'hFFFFFF, 12'hFFF, 16'hFFFF);
        write_delay(28'hFFFFFFF);
        send_request(OP_TICK, 24'h7FFFFF, 0, 0);
        write_delay(28'h0018000);
        send_request(OP_TICK, 24'h7FFFFF, 0, 0);
        send_request(OP_TICK_OUT, 0, 0, 0);

        // random phases across delay settings and idle patterns
        write_delay(28'h0000000);
        random_phase(150);
        write_delay(28'h0FFFFFF);
        random_phase(150);
        send_idle_pct = 52;
        recv_idle_pct = 16;
        dly = DELAY_W'($urandom_range(32'h0FF_0000));
        write_delay(dly);
        random_phase(150);
        // long receiver stall so the pipeline backs up
        hold_off = 300;
        random_phase(50);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_delay(28'h0028000 + DELAY_W'($urandom_range(16'hFFFF)));
        random_phase(150);
        write_delay(DELAY_W'($urandom));
        random_phase(150);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/lfd_pkg.sv
hdl/lagrange_frac_delay_line.sv
verif/lagrange_frac_delay_line_tb.sv
